// ----- design/lst_pkg.sv -----
`default_nettype none
package lst_pkg;

  localparam int NUM_PORTS = 4;
  localparam int ADDR_BITS = 8;

  localparam int PORT_W  = $clog2(NUM_PORTS);
  localparam int PPORT_W = $clog2(NUM_PORTS + 1);
  localparam int ID_W    = 8;

  typedef enum logic [1:0] {
    KIND_DIRECT   = 2'd0,
    KIND_FLOOD    = 2'd1,
    KIND_ANNOUNCE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]      port;
    logic            packet_valid;
    logic [7:0]      packet_tag;
    logic [7:0]      src_addr;
    logic [7:0]      dst_addr;
    logic            is_control;
    logic [ID_W-1:0] leader_id;
    logic [7:0]      leader_distance;
    logic            marks_child;
  } in_word_t;

  typedef struct packed {
    logic [1:0]      out_port;
    logic [1:0]      kind;
    logic [7:0]      packet_tag_out;
    logic [7:0]      src_out;
    logic [7:0]      dst_out;
    logic [ID_W-1:0] leader_out;
    logic [7:0]      distance_out;
    logic            parent_mark;
    logic [3:0]      child_mask;
    logic [2:0]      parent_port;
    logic            last;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic  take;
    logic  lookup;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  emit;
    kind_e emit_kind;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic item_data;
    logic found;
    logic cnt_last;
    logic cnt_is_port;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- design/lst_in_if.sv -----
`default_nettype none
interface lst_in_if;
  import lst_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/lst_out_if.sv -----
`default_nettype none
interface lst_out_if;
  import lst_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/learning_switch_tree_election.sv -----
`default_nettype none
// Learning switch with spanning-tree leader election. Each input word is one
// port poll; a data packet teaches its source address to the polled port and
// is sent to the highest port whose learned address matches its destination,
// or flooded to every other port. A control packet clears the port's address,
// may adopt a smaller leader id (parent becomes the polled port, distance the
// neighbor's plus one, saturating at 255) and may set the port's child bit.
// Every poll ends with one announcement word per port, the last one flagged.
// Writing own_id restarts the election but keeps the address table and child
// bits; write it only while no poll is in flight. Output words leave through
// a single output register, one word per cycle at most. A poll runs through
// an accept state, a lookup state for a data packet, a data state that sends
// the directed word or the flooded words (passing over the polled port), and
// an announce state; each state that emits waits while the output side stalls.
module learning_switch_tree_election (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  lst_in_if.sink          in_i,
  lst_out_if.source       out_o
);
  import lst_pkg::*;

  cmd_t      cmd;
  status_t   status;
  logic      out_valid;
  out_word_t out_data;

  lst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_ready_i (out_o.ready)
  );

  assign in_i.ready  = cmd.take;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule
`default_nettype wire

// ----- design/lst_ctrl.sv -----
`default_nettype none
module lst_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire lst_pkg::status_t status_i,
  output lst_pkg::cmd_t        cmd_o
);
  import lst_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;
  localparam logic [1:0] S_ANN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o.take      = 1'b0;
    cmd_o.lookup    = 1'b0;
    cmd_o.cnt_clr   = 1'b0;
    cmd_o.cnt_inc   = 1'b0;
    cmd_o.emit      = 1'b0;
    cmd_o.emit_kind = KIND_ANNOUNCE;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (in_valid_i) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = status_i.item_data ? S_LOOK : S_ANN;
        end
      end
      S_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d = S_DATA;
      end
      S_DATA: begin
        if (status_i.found) begin
          if (status_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = KIND_DIRECT;
            cmd_o.cnt_clr   = 1'b1;
            state_d = S_ANN;
          end
        end else if (status_i.cnt_is_port || status_i.out_free) begin
          // The polled port is skipped without using an output slot.
          cmd_o.emit      = !status_i.cnt_is_port;
          cmd_o.emit_kind = KIND_FLOOD;
          if (status_i.cnt_last) begin
            cmd_o.cnt_clr = 1'b1;
            state_d = S_ANN;
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
      end
      S_ANN: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.cnt_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/lst_dp.sv -----
`default_nettype none
module lst_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  input  wire lst_pkg::in_word_t in_data_i,
  input  wire lst_pkg::cmd_t     cmd_i,
  output lst_pkg::status_t       status_o,
  output logic                   out_valid_o,
  output lst_pkg::out_word_t     out_data_o,
  input  wire logic              out_ready_i
);
  import lst_pkg::*;

  in_word_t               item_q;
  logic [ADDR_BITS-1:0]   addr_q [NUM_PORTS];
  logic [NUM_PORTS-1:0]   addr_vld_q;
  logic [ID_W-1:0]        leader_q;
  logic [7:0]             dist_q;
  logic [PPORT_W-1:0]     parent_q;
  logic [NUM_PORTS-1:0]   child_q;
  logic [PORT_W-1:0]      cnt_q;
  logic [PORT_W-1:0]      target_q;
  logic                   found_q;
  logic                   out_valid_q;
  out_word_t              out_q;

  logic                   fire;
  logic                   in_range;
  logic [PORT_W-1:0]      in_port;
  logic [PORT_W-1:0]      target_d;
  logic                   found_d;
  logic [7:0]             nd_inc;
  logic                   out_free;
  out_word_t              word_d;

  assign fire     = cmd_i.take && in_valid_i;
  assign in_port  = PORT_W'(in_data_i.port);
  assign in_range = PPORT_W'(in_data_i.port) < PPORT_W'(NUM_PORTS);
  assign nd_inc   = (in_data_i.leader_distance == 8'hFF) ? 8'hFF
                                                         : in_data_i.leader_distance + 8'd1;
  assign out_free = !out_valid_q || out_ready_i;

  // Learning and election updates land at the accept edge, ahead of lookup.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_vld_q <= '0;
      leader_q   <= '0;
      dist_q     <= '0;
      parent_q   <= PPORT_W'(NUM_PORTS);
      child_q    <= '0;
    end else if (cfg_we_i) begin
      leader_q <= cfg_wdata_i;
      dist_q   <= '0;
      parent_q <= PPORT_W'(NUM_PORTS);
    end else if (fire && in_data_i.packet_valid && in_range) begin
      if (!in_data_i.is_control) begin
        addr_vld_q[in_port] <= 1'b1;
      end else begin
        addr_vld_q[in_port] <= 1'b0;
        if (in_data_i.leader_id < leader_q) begin
          parent_q <= PPORT_W'(in_data_i.port);
          dist_q   <= nd_inc;
          leader_q <= in_data_i.leader_id;
        end
        if (in_data_i.marks_child) begin
          child_q[in_port] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      item_q <= in_data_i;
      if (in_data_i.packet_valid && in_range && !in_data_i.is_control) begin
        addr_q[in_port] <= in_data_i.src_addr[ADDR_BITS-1:0];
      end
    end
  end

  // Highest matching port wins.
  always_comb begin
    target_d = '0;
    found_d  = 1'b0;
    for (int j = 0; j < NUM_PORTS; j++) begin
      if (addr_vld_q[j] && addr_q[j] == item_q.dst_addr[ADDR_BITS-1:0]) begin
        target_d = PORT_W'(j);
        found_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      target_q <= target_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + PORT_W'(1);
    end
  end

  always_comb begin
    word_d = '0;
    if (cmd_i.emit_kind == KIND_ANNOUNCE) begin
      word_d.out_port     = 2'(cnt_q);
      word_d.kind         = KIND_ANNOUNCE;
      word_d.leader_out   = leader_q;
      word_d.distance_out = dist_q;
      word_d.parent_mark  = PPORT_W'(cnt_q) == parent_q;
      word_d.child_mask   = 4'(child_q);
      word_d.parent_port  = 3'(parent_q);
      word_d.last         = cnt_q == PORT_W'(NUM_PORTS - 1);
    end else begin
      word_d.out_port       = (cmd_i.emit_kind == KIND_DIRECT) ? 2'(target_q) : 2'(cnt_q);
      word_d.kind           = cmd_i.emit_kind;
      word_d.packet_tag_out = item_q.packet_tag;
      word_d.src_out        = 8'(item_q.src_addr[ADDR_BITS-1:0]);
      word_d.dst_out        = 8'(item_q.dst_addr[ADDR_BITS-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= word_d;
    end
  end

  assign status_o.item_data   = in_data_i.packet_valid && in_range && !in_data_i.is_control;
  assign status_o.found       = found_q;
  assign status_o.cnt_last    = cnt_q == PORT_W'(NUM_PORTS - 1);
  assign status_o.cnt_is_port = cnt_q == PORT_W'(item_q.port);
  assign status_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
